// ===== rtl/chte_pkg.sv =====
`default_nettype none
package chte_pkg;

	localparam int ENTRIES   = 64;
	localparam int BUCKETS   = 97;
	localparam int KEY_CHARS = 10;
	localparam int KEY_BYTES = 10;

	localparam int ENTRY_W  = $clog2(ENTRIES);
	localparam int LINK_W   = 7;
	localparam int BUCKET_W = 7;
	localparam int SUM_W    = $clog2(KEY_BYTES * 255 + 1);

	localparam int MOD_SHIFT = 20;
	localparam int RECIP     = ((1 << MOD_SHIFT) + BUCKETS - 1) / BUCKETS;
	localparam int RECIP_W   = $clog2(RECIP + 1);

	localparam logic [LINK_W-1:0] EMPTY_LINK = 7'd127;

	typedef enum logic [1:0] {
		CMD_SEARCH = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_SPARE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_PRESENT = 2'd1,
		ST_ABSENT  = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] key_head;
		logic [15:0] key_tail;
	} req_beat_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] entry_index;
		logic [6:0] bucket;
	} res_beat_t;

	typedef struct packed {
		logic                key_we;
		logic                link_we;
		logic [ENTRY_W-1:0]  addr;
		logic [63:0]         key_head;
		logic [15:0]         key_tail;
		logic [LINK_W-1:0]   link;
	} ent_wr_t;

endpackage
`default_nettype wire

// ===== rtl/chained_hash_table_engine.sv =====
`default_nettype none
// Sequence: S_MOD1 and S_MOD2 reduce the key sum, S_HEAD reads the bucket, S_WALK and S_CMP visit each entry,
// S_ACT ends the walk, then S_INS for an insert or S_DEL and S_FREE for a delete that unlinks.
// Throughput: one command at a time; busy drops in the cycle the result beat is presented.
// The chain walk through the entry memory (one read per visited entry) sets the rate.
// Reset: async active low; table empty, free list 0..ENTRIES-1 in order.
// The result beat on done lasts one cycle; the receiver cannot stall it.
module chained_hash_table_engine
	import chte_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire req_beat_t request,
	output logic           done,
	output res_beat_t      result
);

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_MOD1 = 10'b0000000010,
		S_MOD2 = 10'b0000000100,
		S_HEAD = 10'b0000001000,
		S_WALK = 10'b0000010000,
		S_CMP  = 10'b0000100000,
		S_ACT  = 10'b0001000000,
		S_INS  = 10'b0010000000,
		S_DEL  = 10'b0100000000,
		S_FREE = 10'b1000000000
	} state_t;

	state_t              state_q;
	logic [1:0]          cmd_q;
	logic [63:0]         key_head_q;
	logic [15:0]         key_tail_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    quot_q;
	logic [BUCKET_W-1:0] h_q;
	logic [LINK_W-1:0]   head_q;
	logic [LINK_W-1:0]   idx_q;
	logic [LINK_W-1:0]   prev_q;
	logic [LINK_W-1:0]   nxt_q;
	logic [LINK_W-1:0]   free_q;
	logic [ENTRY_W:0]    steps_q;
	logic                found_q;
	logic                done_q;
	res_beat_t           result_q;

	logic [63:0]         clean_head;
	logic [15:0]         clean_tail;
	logic [SUM_W-1:0]    sum;
	logic [SUM_W+RECIP_W-1:0] prod;
	logic [SUM_W-1:0]    rem;
	logic [BUCKET_W-1:0] h;

	logic [BUCKET_W-1:0] bkt_rd_addr;
	logic [LINK_W-1:0]   bkt_rd_data;
	logic                bkt_we;
	logic [BUCKET_W-1:0] bkt_wr_addr;
	logic [LINK_W-1:0]   bkt_wr_data;

	logic [ENTRY_W-1:0]  ent_rd_addr;
	logic [63:0]         ent_key_head;
	logic [15:0]         ent_key_tail;
	logic [LINK_W-1:0]   ent_link;
	ent_wr_t             ent_wr;

	logic                key_match;

	chte_hash u_hash (
		.key_head   (request.key_head),
		.key_tail   (request.key_tail),
		.clean_head (clean_head),
		.clean_tail (clean_tail),
		.sum        (sum)
	);

	chte_bucket_ram u_bucket_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (bkt_rd_addr),
		.rd_data (bkt_rd_data),
		.we      (bkt_we),
		.wr_addr (bkt_wr_addr),
		.wr_data (bkt_wr_data)
	);

	chte_entry_ram u_entry_ram (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_addr     (ent_rd_addr),
		.rd_key_head (ent_key_head),
		.rd_key_tail (ent_key_tail),
		.rd_link     (ent_link),
		.wr          (ent_wr)
	);

	assign prod = (SUM_W+RECIP_W)'(sum_q) * (SUM_W+RECIP_W)'(RECIP);

	always_comb begin
		rem = sum_q - SUM_W'(quot_q * SUM_W'(BUCKETS));
		if (rem >= SUM_W'(BUCKETS)) begin
			rem = rem - SUM_W'(BUCKETS);
		end
		h = rem[BUCKET_W-1:0];
	end

	assign key_match = (ent_key_head == key_head_q) && (ent_key_tail == key_tail_q);

	always_comb begin
		bkt_rd_addr = h;
		ent_rd_addr = (state_q == S_ACT) ? free_q[ENTRY_W-1:0] : idx_q[ENTRY_W-1:0];
		bkt_we      = 1'b0;
		bkt_wr_addr = h_q;
		bkt_wr_data = nxt_q;
		ent_wr      = '0;
		ent_wr.key_head = key_head_q;
		ent_wr.key_tail = key_tail_q;
		case (state_q)
			S_INS: begin
				bkt_we         = 1'b1;
				bkt_wr_data    = free_q;
				ent_wr.key_we  = 1'b1;
				ent_wr.link_we = 1'b1;
				ent_wr.addr    = free_q[ENTRY_W-1:0];
				ent_wr.link    = head_q;
			end
			S_DEL: begin
				if (prev_q < LINK_W'(ENTRIES)) begin
					ent_wr.link_we = 1'b1;
					ent_wr.addr    = prev_q[ENTRY_W-1:0];
					ent_wr.link    = nxt_q;
				end else begin
					bkt_we = 1'b1;
				end
			end
			S_FREE: begin
				ent_wr.link_we = 1'b1;
				ent_wr.addr    = idx_q[ENTRY_W-1:0];
				ent_wr.link    = free_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q      <= request.command;
				key_head_q <= clean_head;
				key_tail_q <= clean_tail;
				sum_q      <= sum;
			end
			S_MOD1: begin
				quot_q <= SUM_W'(prod[SUM_W+RECIP_W-1:MOD_SHIFT]);
			end
			S_MOD2: begin
				h_q <= h;
			end
			S_HEAD: begin
				head_q  <= bkt_rd_data;
				idx_q   <= bkt_rd_data;
				prev_q  <= EMPTY_LINK;
			end
			S_CMP: begin
				if (key_match) begin
					nxt_q <= ent_link;
				end else begin
					prev_q <= idx_q;
					idx_q  <= ent_link;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			free_q   <= '0;
			steps_q  <= '0;
			found_q  <= 1'b0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= S_MOD1;
					end
				end
				S_MOD1: begin
					done_q  <= 1'b0;
					state_q <= S_MOD2;
				end
				S_MOD2: begin
					done_q  <= 1'b0;
					state_q <= S_HEAD;
				end
				S_HEAD: begin
					done_q  <= 1'b0;
					steps_q <= '0;
					found_q <= 1'b0;
					state_q <= S_WALK;
				end
				S_WALK: begin
					done_q <= 1'b0;
					if (idx_q >= LINK_W'(ENTRIES) || steps_q == (ENTRY_W+1)'(ENTRIES)) begin
						state_q <= S_ACT;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					done_q <= 1'b0;
					if (key_match) begin
						found_q <= 1'b1;
						state_q <= S_ACT;
					end else begin
						steps_q <= steps_q + 1'b1;
						state_q <= S_WALK;
					end
				end
				S_ACT: begin
					result_q.bucket <= h_q;
					case (cmd_q)
						CMD_INSERT: begin
							if (found_q) begin
								result_q.status      <= ST_PRESENT;
								result_q.entry_index <= idx_q[5:0];
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else if (free_q >= LINK_W'(ENTRIES)) begin
								result_q.status      <= ST_FULL;
								result_q.entry_index <= '0;
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								done_q  <= 1'b0;
								state_q <= S_INS;
							end
						end
						CMD_DELETE: begin
							if (found_q) begin
								done_q  <= 1'b0;
								state_q <= S_DEL;
							end else begin
								result_q.status      <= ST_ABSENT;
								result_q.entry_index <= '0;
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						end
						default: begin
							if (found_q) begin
								result_q.status      <= ST_OK;
								result_q.entry_index <= idx_q[5:0];
							end else begin
								result_q.status      <= ST_ABSENT;
								result_q.entry_index <= '0;
							end
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_INS: begin
					free_q               <= ent_link;
					result_q.status      <= ST_OK;
					result_q.entry_index <= free_q[5:0];
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_DEL: begin
					done_q  <= 1'b0;
					state_q <= S_FREE;
				end
				S_FREE: begin
					free_q               <= idx_q;
					result_q.status      <= ST_OK;
					result_q.entry_index <= idx_q[5:0];
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

// ===== rtl/chte_hash.sv =====
`default_nettype none
module chte_hash
	import chte_pkg::*;
(
	input  wire logic [63:0]      key_head,
	input  wire logic [15:0]      key_tail,
	output logic [63:0]           clean_head,
	output logic [15:0]           clean_tail,
	output logic [SUM_W-1:0]      sum
);

	logic [KEY_BYTES*8-1:0] raw;
	logic [KEY_BYTES*8-1:0] clean;
	logic                   ended;
	logic [7:0]             v;

	assign raw = {key_head, key_tail};

	always_comb begin
		ended = 1'b0;
		sum   = '0;
		clean = '0;
		v     = '0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			v = raw[KEY_BYTES*8-1-8*i -: 8];
			if (i >= KEY_CHARS || v == 8'd0) begin
				ended = 1'b1;
			end
			if (ended) begin
				v = 8'd0;
			end
			clean[KEY_BYTES*8-1-8*i -: 8] = v;
			sum = sum + SUM_W'(v);
		end
	end

	assign clean_head = clean[79:16];
	assign clean_tail = clean[15:0];

endmodule
`default_nettype wire

// ===== rtl/chte_bucket_ram.sv =====
`default_nettype none
module chte_bucket_ram
	import chte_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [BUCKET_W-1:0] rd_addr,
	output logic [LINK_W-1:0]        rd_data,
	input  wire logic                we,
	input  wire logic [BUCKET_W-1:0] wr_addr,
	input  wire logic [LINK_W-1:0]   wr_data
);

	logic [LINK_W-1:0] mem [BUCKETS];
	logic [BUCKETS-1:0] vld_q;
	logic [LINK_W-1:0] data_s1;
	logic              vld_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (we) begin
				vld_q[wr_addr] <= 1'b1;
			end
			vld_s1 <= vld_q[rd_addr];
		end
	end

	assign rd_data = vld_s1 ? data_s1 : EMPTY_LINK;

endmodule
`default_nettype wire

// ===== rtl/chte_entry_ram.sv =====
`default_nettype none
module chte_entry_ram
	import chte_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [ENTRY_W-1:0] rd_addr,
	output logic [63:0]             rd_key_head,
	output logic [15:0]             rd_key_tail,
	output logic [LINK_W-1:0]       rd_link,
	input  wire ent_wr_t            wr
);

	logic [63:0]       key_head_mem [ENTRIES];
	logic [15:0]       key_tail_mem [ENTRIES];
	logic [LINK_W-1:0] link_mem     [ENTRIES];
	logic [ENTRIES-1:0] link_vld_q;
	logic [LINK_W-1:0] link_s1;
	logic              vld_s1;
	logic [ENTRY_W-1:0] addr_s1;
	logic [LINK_W:0]   next_idx;

	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			key_head_mem[wr.addr] <= wr.key_head;
			key_tail_mem[wr.addr] <= wr.key_tail;
		end
		if (wr.link_we) begin
			link_mem[wr.addr] <= wr.link;
		end
		rd_key_head <= key_head_mem[rd_addr];
		rd_key_tail <= key_tail_mem[rd_addr];
		link_s1     <= link_mem[rd_addr];
		addr_s1     <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q <= '0;
			vld_s1     <= 1'b0;
		end else begin
			if (wr.link_we) begin
				link_vld_q[wr.addr] <= 1'b1;
			end
			vld_s1 <= link_vld_q[rd_addr];
		end
	end

	assign next_idx = (LINK_W+1)'(addr_s1) + 1'b1;

	always_comb begin
		if (vld_s1) begin
			rd_link = link_s1;
		end else if (next_idx < (LINK_W+1)'(ENTRIES)) begin
			rd_link = next_idx[LINK_W-1:0];
		end else begin
			rd_link = EMPTY_LINK;
		end
	end

endmodule
`default_nettype wire

// ===== dv/chained_hash_table_engine_tb.sv =====
`timescale 1ns / 1ps
module chained_hash_table_engine_tb;
	import chte_pkg::*;

	class hash_set_scoreboard;
		logic [6:0]  heads [BUCKETS];
		logic [63:0] kheads [ENTRIES];
		logic [15:0] ktails [ENTRIES];
		logic [6:0]  links [ENTRIES];
		logic [6:0]  free_top;
		res_beat_t   pending [$];
		int          errors;
		int          checked;
		int          st_seen [4];

		function void clear_table();
			for (int i = 0; i < BUCKETS; i++) heads[i] = EMPTY_LINK;
			for (int i = 0; i < ENTRIES; i++) begin
				kheads[i] = '0;
				ktails[i] = '0;
				links[i] = (i + 1 < ENTRIES) ? 7'(i + 1) : EMPTY_LINK;
			end
			free_top = '0;
		endfunction

		function void note_command(req_beat_t rq);
			logic [7:0]  b [KEY_BYTES];
			logic [63:0] kh;
			logic [15:0] kt;
			int          sum;
			int          h;
			int          idx;
			int          prv;
			int          steps;
			int          x;
			bit          ended;
			bit          found;
			res_beat_t   r;
			sum = 0;
			ended = 0;
			found = 0;
			for (int i = 0; i < KEY_BYTES; i++) begin
				b[i] = (i < 8) ? rq.key_head[63 - 8 * i -: 8] : rq.key_tail[15 - 8 * (i - 8) -: 8];
				if (i >= KEY_CHARS || b[i] == 0) ended = 1;
				if (ended) b[i] = 0;
				sum += b[i];
			end
			kh = {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
			kt = {b[8], b[9]};
			h = sum % BUCKETS;
			prv = EMPTY_LINK;
			idx = heads[h];
			steps = 0;
			while (idx < ENTRIES && steps < ENTRIES) begin
				if (kheads[idx] == kh && ktails[idx] == kt) begin
					found = 1;
					break;
				end
				prv = idx;
				idx = links[idx];
				steps++;
			end
			r.bucket = 7'(h);
			r.entry_index = '0;
			case (cmd_t'(rq.command))
				CMD_INSERT: begin
					if (found) begin
						r.status = ST_PRESENT;
						r.entry_index = 6'(idx);
					end else if (free_top >= ENTRIES) begin
						r.status = ST_FULL;
					end else begin
						x = free_top;
						free_top = links[x];
						kheads[x] = kh;
						ktails[x] = kt;
						links[x] = heads[h];
						heads[h] = 7'(x);
						r.status = ST_OK;
						r.entry_index = 6'(x);
					end
				end
				CMD_DELETE: begin
					if (!found) begin
						r.status = ST_ABSENT;
					end else begin
						if (prv < ENTRIES) links[prv] = links[idx];
						else heads[h] = links[idx];
						links[idx] = free_top;
						free_top = 7'(idx);
						r.status = ST_OK;
						r.entry_index = 6'(idx);
					end
				end
				default: begin
					r.status = found ? ST_OK : ST_ABSENT;
					if (found) r.entry_index = 6'(idx);
				end
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(res_beat_t got);
			res_beat_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			checked++;
			st_seen[got.status]++;
			if (got.status !== exp.status) begin
				$display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
				errors++;
			end
			if (got.entry_index !== exp.entry_index) begin
				$display("%0t: entry_index exp %0d got %0d", $time, exp.entry_index,
					got.entry_index);
				errors++;
			end
			if (got.bucket !== exp.bucket) begin
				$display("%0t: bucket exp %0d got %0d", $time, exp.bucket, got.bucket);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	req_beat_t request;
	logic      done;
	res_beat_t result;
	int        idle_pct;
	hash_set_scoreboard hset;
	logic [63:0] key_pool_h [16];
	logic [15:0] key_pool_t [16];

	chained_hash_table_engine u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .done(done), .result(result)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if (done) hset.check_result(result);
	end

	// one command beat; random idle before it
	task automatic send_cmd(logic [1:0] cmd, logic [63:0] kh, logic [15:0] kt);
		while ($urandom_range(99) < idle_pct) @(posedge clk);
		start <= 1'b1;
		request <= '{command: cmd, key_head: kh, key_tail: kt};
		@(posedge clk);
		while (busy) @(posedge clk);
		hset.note_command(request);
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		int n;
		n = 0;
		while (hset.pending.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
	endtask

	function automatic logic [63:0] rand_key_head();
		logic [63:0] k;
		int len;
		k = {$urandom, $urandom};
		len = $urandom_range(8);
		for (int i = 0; i < 8; i++)
			if (i >= len) k[63 - 8 * i -: 8] = 8'h00;
		return k;
	endfunction

	initial begin
		logic [1:0] c;
		logic [63:0] kh;
		logic [15:0] kt;
		int p;
		hset = new();
		hset.clear_table();
		start = 1'b0;
		request = '0;
		idle_pct = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, garbage after terminator, spare code, full pool
		send_cmd(CMD_SEARCH, 64'h0, 16'h0);
		send_cmd(CMD_INSERT, 64'h0, 16'h0);
		send_cmd(CMD_INSERT, 64'h0, 16'hFFFF);
		send_cmd(CMD_INSERT, '1, '1);
		send_cmd(CMD_SEARCH, '1, '1);
		send_cmd(CMD_SPARE, '1, 16'hFF00);
		send_cmd(CMD_INSERT, 64'h4100_FFFF_FFFF_FFFF, 16'h1234);
		send_cmd(CMD_SEARCH, 64'h4100_0000_0000_0000, 16'h0);
		send_cmd(CMD_DELETE, 64'h4100_0000_0000_0000, 16'h0);
		send_cmd(CMD_DELETE, 64'h4100_0000_0000_0000, 16'h0);
		send_cmd(CMD_INSERT, 64'h0102_0304_0506_0708, 16'h090A);
		send_cmd(CMD_INSERT, 64'h0A09_0807_0605_0403, 16'h0201);
		send_cmd(CMD_DELETE, 64'h0102_0304_0506_0708, 16'h090A);
		send_cmd(CMD_SEARCH, 64'h0A09_0807_0605_0403, 16'h0201);
		send_cmd(CMD_DELETE, '1, '1);
		for (int i = 0; i < 70; i++)
			send_cmd(CMD_INSERT, {48'h0101_0101_0101, 8'(i + 1), 8'h01}, 16'h0);
		send_cmd(CMD_SPARE, 64'h0, 16'h0);
		drain();
		for (int i = 0; i < 70; i++)
			send_cmd(CMD_DELETE, {48'h0101_0101_0101, 8'(i + 1), 8'h01}, 16'h0);
		drain();

		for (int i = 0; i < 16; i++) begin
			key_pool_h[i] = rand_key_head();
			key_pool_t[i] = (key_pool_h[i][7:0] != 0) ? 16'($urandom) : 16'h0;
		end
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 0) ? 0 : (ph == 1) ? 45 : (ph == 2) ? 0 : 32;
			for (int i = 0; i < 90; i++) begin
				c = 2'($urandom_range(3));
				p = $urandom_range(99);
				if (p < 70) begin
					kh = key_pool_h[$urandom_range(15)];
					kt = key_pool_t[$urandom_range(15)];
					if ($urandom_range(3) != 0) begin
						p = $urandom_range(15);
						kh = key_pool_h[p];
						kt = key_pool_t[p];
					end
				end else begin
					kh = {$urandom, $urandom};
					kt = 16'($urandom);
				end
				send_cmd(c, kh, kt);
			end
			drain();
		end
		drain();
		repeat (100) @(posedge clk);
		$display("Covered %0d commands: ok %0d, present %0d, absent %0d, full %0d.",
			hset.checked, hset.st_seen[0], hset.st_seen[1], hset.st_seen[2],
			hset.st_seen[3]);
		if (hset.errors == 0 && hset.pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
